>>> design/diagrt_pkg.sv
// Package for the diagnostic route table: sizes, command and status codes,
// the route entry layout and the default routes.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package diagrt_pkg;

	localparam int ROUTE_SLOTS          = 32;
	localparam int MESSAGE_BUFFER_BYTES = 256;

	localparam int IDX_W = $clog2(ROUTE_SLOTS);
	localparam int CNT_W = $clog2(ROUTE_SLOTS + 1);

	localparam int CMD_W = 3;
	localparam int LEN_W = 12;
	localparam int MATCH_W = 6;

	localparam logic [CMD_W-1:0] CMD_ADD     = 3'd0;
	localparam logic [CMD_W-1:0] CMD_REMOVE  = 3'd1;
	localparam logic [CMD_W-1:0] CMD_MESSAGE = 3'd2;
	localparam logic [CMD_W-1:0] CMD_DEINIT  = 3'd3;
	localparam logic [CMD_W-1:0] CMD_INIT    = 3'd4;

	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_ERROR   = 2'd1;
	localparam logic [1:0] ST_INVALID = 2'd2;

	localparam logic [15:0]      SERVICE_WILDCARD  = 16'hFFFF;
	localparam logic [LEN_W-1:0] MIN_MESSAGE_BYTES = LEN_W'(4);
	localparam logic [LEN_W-1:0] MSG_BUF_BYTES     = LEN_W'(MESSAGE_BUFFER_BYTES);
	localparam logic [7:0]       DEFAULT_SOURCE    = 8'h01;
	localparam int               DEFAULT_ROUTES    = 3;

	typedef struct packed {
		logic [15:0] service;
		logic [7:0]  target;
		logic [7:0]  source;
	} route_entry_t;

	localparam int ENTRY_W = $bits(route_entry_t);

	// Default routes: source 0x01, targets 0xF1..0xF3, wildcard service
	function automatic route_entry_t default_entry(input logic [1:0] idx);
		route_entry_t e;
		e.source  = DEFAULT_SOURCE;
		e.target  = 8'hF1 + {6'd0, idx};
		e.service = SERVICE_WILDCARD;
		return e;
	endfunction

endpackage

`default_nettype wire

>>> design/diagrt_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module diagrt_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 32
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

>>> design/diag_route_table_unit.sv
// Route table for diagnostic messages: command decode, table scan and result register.
// Depends on diagrt_pkg and diagrt_ram.
//
// Usage: one command per slave-side transaction (s_tuser = command, s_tdata =
// source, target, service, length). Each command yields exactly one result
// transaction on the master side (status, match count, forwarded flag).
// Route entries sit in a synchronous RAM with registered read data; active
// bits, the route count and the ready flag are flip-flops.
// Add, remove and message walk the table one entry per cycle through the RAM
// read port, then pass their result to the result register; remove and
// duplicate add stop at the first hit. Deinit, init, unknown codes and commands
// rejected on their parameters skip the walk and go straight to the result
// register.
// s_tready is high while no command is in progress; the result register lets
// the next command start while the last result still waits.
// When the receiver stalls with a result pending, a finished command waits
// until the register frees up.
// Reset (asynchronous) restores the three default routes with no clearing
// pass: the first three slots read as defaults until they are rewritten.
`timescale 1ns / 1ps
`default_nettype none

module diag_route_table_unit (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [47:0] s_tdata,  // source[7:0], target[15:8], service[31:16], length[43:32]
	input  wire logic [2:0]  s_tuser,  // command[2:0]
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic      [15:0] m_tdata   // status[1:0], match_count[7:2], forwarded[8]
);

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_SCAN = 2'd1;
	localparam logic [1:0] S_RESP = 2'd2;

	localparam int SLOTS = diagrt_pkg::ROUTE_SLOTS;
	localparam int IW    = diagrt_pkg::IDX_W;
	localparam int CW    = diagrt_pkg::CNT_W;
	localparam int MW    = diagrt_pkg::MATCH_W;
	localparam int LW    = diagrt_pkg::LEN_W;
	localparam int DEFN  = diagrt_pkg::DEFAULT_ROUTES;

	logic [1:0]  state_q;
	logic [2:0]  cmd_q;
	logic [7:0]  src_q;
	logic [7:0]  tgt_q;
	logic [15:0] svc_q;
	logic [LW-1:0] len_q;

	logic [SLOTS-1:0] active_q;
	logic [CW-1:0]    count_q;
	logic             ready_q;
	logic [DEFN-1:0]  preset_q;

	logic [CW-1:0] rd_idx_q;
	logic          vld_s1;
	logic [IW-1:0] idx_s1;
	logic          dflt_s1;
	logic [MW-1:0] match_cnt_q;

	logic [1:0]    res_status_q;
	logic [MW-1:0] res_match_q;
	logic          res_fwd_q;

	logic          m_tvalid_q;
	logic [15:0]   m_tdata_q;

	// incoming fields
	logic [2:0]    in_cmd;
	logic [7:0]    in_src;
	logic [7:0]    in_tgt;
	logic [15:0]   in_svc;
	logic [LW-1:0] in_len;

	assign in_cmd = s_tuser;
	assign in_src = s_tdata[7:0];
	assign in_tgt = s_tdata[15:8];
	assign in_svc = s_tdata[31:16];
	assign in_len = s_tdata[43:32];

	// RAM
	logic                      ram_we;
	logic                      ram_re;
	logic [diagrt_pkg::ENTRY_W-1:0] ram_rdata;
	diagrt_pkg::route_entry_t  wr_entry;

	// scan datapath
	diagrt_pkg::route_entry_t ent;
	logic in_scan;
	logic key_hit, add_hit, msg_hit, stop_hit, scan_end, issue;
	logic rd_dflt;
	logic load_out;
	logic table_full;

	assign in_scan    = (state_q == S_SCAN);
	assign table_full = (count_q >= CW'(SLOTS));

	assign ent = dflt_s1 ? diagrt_pkg::default_entry(idx_s1[1:0])
	                     : diagrt_pkg::route_entry_t'(ram_rdata);

	assign key_hit = (ent.source == src_q) && (ent.target == tgt_q);
	assign add_hit = key_hit && (ent.service == svc_q);
	assign msg_hit = active_q[idx_s1] && key_hit &&
	                 ((ent.service == diagrt_pkg::SERVICE_WILDCARD) ||
	                  (ent.service == {8'h00, svc_q[7:0]}));

	assign stop_hit = vld_s1 && (((cmd_q == diagrt_pkg::CMD_ADD) && add_hit) ||
	                             ((cmd_q == diagrt_pkg::CMD_REMOVE) && key_hit));
	assign scan_end = !vld_s1 && (rd_idx_q >= count_q);
	assign issue    = in_scan && (rd_idx_q < count_q) && !stop_hit;
	assign ram_re   = issue;

	// slots below DEFN read as defaults until rewritten after reset or init
	always_comb begin
		rd_dflt = 1'b0;
		for (int k = 0; k < DEFN; k++) begin
			if (rd_idx_q == CW'(k)) begin
				rd_dflt = preset_q[k];
			end
		end
	end

	assign ram_we = in_scan && scan_end && (cmd_q == diagrt_pkg::CMD_ADD) && !table_full;
	assign wr_entry.source  = src_q;
	assign wr_entry.target  = tgt_q;
	assign wr_entry.service = svc_q;

	diagrt_ram #(
		.WIDTH(diagrt_pkg::ENTRY_W),
		.DEPTH(SLOTS)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (count_q[IW-1:0]),
		.wdata (wr_entry),
		.re    (ram_re),
		.raddr (rd_idx_q[IW-1:0]),
		.rdata (ram_rdata)
	);

	assign s_tready = (state_q == S_IDLE);
	assign load_out = (state_q == S_RESP) && (!m_tvalid_q || m_tready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			cmd_q        <= '0;
			src_q        <= '0;
			tgt_q        <= '0;
			svc_q        <= '0;
			len_q        <= '0;
			active_q     <= SLOTS'((1 << DEFN) - 1);
			count_q      <= CW'(DEFN);
			ready_q      <= 1'b1;
			preset_q     <= '1;
			rd_idx_q     <= '0;
			vld_s1       <= 1'b0;
			idx_s1       <= '0;
			dflt_s1      <= 1'b0;
			match_cnt_q  <= '0;
			res_status_q <= diagrt_pkg::ST_OK;
			res_match_q  <= '0;
			res_fwd_q    <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (s_tvalid) begin
						cmd_q        <= in_cmd;
						src_q        <= in_src;
						tgt_q        <= in_tgt;
						svc_q        <= in_svc;
						len_q        <= in_len;
						rd_idx_q     <= '0;
						vld_s1       <= 1'b0;
						match_cnt_q  <= '0;
						res_match_q  <= '0;
						res_fwd_q    <= 1'b0;
						res_status_q <= diagrt_pkg::ST_ERROR;
						state_q      <= S_RESP;
						case (in_cmd)
							diagrt_pkg::CMD_ADD: begin
								if (ready_q && (in_src == 8'h00 || in_tgt == 8'h00)) begin
									res_status_q <= diagrt_pkg::ST_INVALID;
								end else if (ready_q) begin
									state_q <= S_SCAN;
								end
							end
							diagrt_pkg::CMD_REMOVE: begin
								if (ready_q) begin
									state_q <= S_SCAN;
								end
							end
							diagrt_pkg::CMD_MESSAGE: begin
								if (!ready_q || in_len == '0) begin
									res_status_q <= diagrt_pkg::ST_INVALID;
								end else if (in_src != 8'h00 && in_tgt != 8'h00 &&
								             in_len >= diagrt_pkg::MIN_MESSAGE_BYTES) begin
									state_q <= S_SCAN;
								end
							end
							diagrt_pkg::CMD_DEINIT: begin
								active_q     <= '0;
								count_q      <= '0;
								ready_q      <= 1'b0;
								res_status_q <= diagrt_pkg::ST_OK;
							end
							diagrt_pkg::CMD_INIT: begin
								if (!ready_q) begin
									active_q     <= SLOTS'((1 << DEFN) - 1);
									count_q      <= CW'(DEFN);
									preset_q     <= '1;
									ready_q      <= 1'b1;
									res_status_q <= diagrt_pkg::ST_OK;
								end
							end
							default: begin
								res_status_q <= diagrt_pkg::ST_ERROR;
							end
						endcase
					end
				end

				S_SCAN: begin
					vld_s1  <= issue;
					idx_s1  <= rd_idx_q[IW-1:0];
					dflt_s1 <= rd_dflt;
					if (issue) begin
						rd_idx_q <= rd_idx_q + CW'(1);
					end
					if (vld_s1 && (cmd_q == diagrt_pkg::CMD_MESSAGE) && msg_hit &&
					    match_cnt_q != '1) begin
						match_cnt_q <= match_cnt_q + MW'(1);
					end
					if (stop_hit) begin
						// add: duplicate found; remove: retire first match
						res_status_q <= diagrt_pkg::ST_OK;
						if (cmd_q == diagrt_pkg::CMD_REMOVE) begin
							active_q[idx_s1] <= 1'b0;
							if ({1'b0, idx_s1} + CW'(1) == count_q) begin
								count_q <= count_q - CW'(1);
							end
						end
						state_q <= S_RESP;
					end else if (scan_end) begin
						state_q <= S_RESP;
						case (cmd_q)
							diagrt_pkg::CMD_ADD: begin
								if (table_full) begin
									res_status_q <= diagrt_pkg::ST_ERROR;
								end else begin
									res_status_q      <= diagrt_pkg::ST_OK;
									active_q[count_q[IW-1:0]] <= 1'b1;
									count_q           <= count_q + CW'(1);
									for (int k = 0; k < DEFN; k++) begin
										if (count_q == CW'(k)) begin
											preset_q[k] <= 1'b0;
										end
									end
								end
							end
							diagrt_pkg::CMD_MESSAGE: begin
								res_match_q  <= match_cnt_q;
								res_status_q <= (match_cnt_q != '0) ? diagrt_pkg::ST_OK
								                                    : diagrt_pkg::ST_ERROR;
								res_fwd_q    <= (match_cnt_q != '0) &&
								                (len_q <= diagrt_pkg::MSG_BUF_BYTES);
							end
							default: begin
								res_status_q <= diagrt_pkg::ST_ERROR;
							end
						endcase
					end
				end

				S_RESP: begin
					if (load_out) begin
						state_q <= S_IDLE;
					end
				end

				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
			m_tdata_q  <= '0;
		end else if (load_out) begin
			m_tvalid_q <= 1'b1;
			m_tdata_q  <= {7'd0, res_fwd_q, res_match_q, res_status_q};
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(SLOTS))
		else $error("route count beyond table size");

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> state_q != S_IDLE)
		else $error("accepted transaction did not start a command");

	a_write_room: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> !table_full && !vld_s1 && !ram_re)
		else $error("table write with no room or during a read");

	a_read_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s1 |-> $past(ram_re) && state_q == S_SCAN)
		else $error("entry evaluated without a matching read");

endmodule

`default_nettype wire
